FILE: rtl/lps_pkg.sv
// Shared types and constants of the linear prime sieve.
package lps_pkg;

    // Default storage sizes
    localparam int SIEVE_SIZE_DEF  = 131072;
    localparam int PRIME_DEPTH_DEF = 16384;

    // Field widths
    localparam int VALUE_W = 17;
    localparam int INDEX_W = 14;
    localparam int TOTAL_W = 15;
    localparam int LIMIT_W = 18;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 18'd131072;

    // Query item
    typedef struct packed {
        logic [VALUE_W-1:0] query_value;
        logic [INDEX_W-1:0] prime_index;
    } t_lps_in;

    // Result item
    typedef struct packed {
        logic               value_is_prime;
        logic [VALUE_W-1:0] nth_prime;
        logic [TOTAL_W-1:0] prime_total;
        logic               index_in_range;
    } t_lps_out;

    // Status of the remainder unit
    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_mod_stat;

    // Controller states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_B_INIT,
        S_B_RDI,
        S_B_CHK,
        S_B_RDP,
        S_B_MUL,
        S_B_MARK,
        S_B_DIV,
        S_B_NEXT,
        S_Q_READ,
        S_Q_OUT
    } t_state;

endpackage

FILE: rtl/lps_ram.sv
// Generic simple dual-port RAM with registered read.
module lps_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/lps_mod.sv
// Bit-serial remainder unit: one restoring step per cycle.
module lps_mod #(
    parameter int W = 17
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [W-1:0]      i_dividend,
    input  logic [W-1:0]      i_divisor,
    output lps_pkg::t_mod_stat o_stat
);

    localparam int CNW = $clog2(W);

    logic           r_busy, n_busy;
    logic           r_done, n_done;
    logic [CNW-1:0] r_cnt, n_cnt;
    logic [W-1:0]   r_rem, n_rem;
    logic [W-1:0]   r_dvd, n_dvd;
    logic [W-1:0]   r_d, n_d;
    logic [W:0]     w_trial;
    logic [W:0]     w_diff;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_dvd[W-1]};
    assign w_diff  = w_trial - {1'b0, r_d};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_d    = r_d;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_d    = i_divisor;
        end else if (r_busy) begin
            n_rem = (w_trial >= {1'b0, r_d}) ? w_diff[W-1:0] : w_trial[W-1:0];
            n_dvd = {r_dvd[W-2:0], 1'b0};
            n_cnt = r_cnt + CNW'(1);
            if (r_cnt == CNW'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_d   <= n_d;
    end

    assign o_stat.done     = r_done;
    assign o_stat.rem_zero = (r_rem == '0);

endmodule

FILE: rtl/linear_prime_sieve.sv
// Linear prime sieve: one-time build into RAM, then queries answered from it.
//
//  channel | valid      | ready       | data        | transfer when
//  --------+------------+-------------+-------------+--------------------------
//  query   | i_in_valid | o_in_ready  | i_in        | i_in_valid && o_in_ready
//  result  | o_out_valid| i_out_ready | o_out       | o_out_valid && i_out_ready
//  config  | i_cfg_valid| o_cfg_ready | i_cfg_data  | i_cfg_valid && o_cfg_ready
//
// After reset a clearing pass writes every composite-map entry, during which
// no query is taken; configuration writes are taken always. The first query
// builds the sieve: each integer is read from the composite map and checked,
// each product tried reads a prime and is multiplied, and each product marked
// waits while the serial remainder unit runs. Afterwards the transfer cycle
// of a query issues the composite-map and prime-list reads, and S_Q_OUT loads
// the output register. A result that waits in the output register holds the
// next query, its reads already issued, until the result transfers.
module linear_prime_sieve #(
    parameter int SIEVE_SIZE  = lps_pkg::SIEVE_SIZE_DEF,
    parameter int PRIME_DEPTH = lps_pkg::PRIME_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  lps_pkg::t_lps_in              i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output lps_pkg::t_lps_out             o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lps_pkg::LIMIT_W-1:0]   i_cfg_data
);

    localparam int NW  = $clog2(SIEVE_SIZE);
    localparam int LW  = $clog2(SIEVE_SIZE + 1);
    localparam int AW  = NW;
    localparam int PAW = $clog2(PRIME_DEPTH);
    localparam int CW  = $clog2(PRIME_DEPTH + 1);
    localparam int PW  = LW + NW;

    lps_pkg::t_state   r_state, n_state;
    logic [lps_pkg::LIMIT_W-1:0] r_limit;
    logic [LW-1:0]     r_lim, n_lim;
    logic              r_built, n_built;
    logic [CW-1:0]     r_pf, n_pf;
    logic [LW-1:0]     r_i, n_i;
    logic [CW-1:0]     r_j, n_j;
    logic [NW-1:0]     r_p, n_p;
    logic [PW-1:0]     r_prod, n_prod;
    logic [AW-1:0]     r_clr, n_clr;
    logic [lps_pkg::VALUE_W-1:0] r_q, n_q;
    logic [lps_pkg::INDEX_W-1:0] r_idx, n_idx;
    lps_pkg::t_lps_out r_out, n_out;
    logic              r_out_valid, n_out_valid;

    // Memory and remainder unit controls
    logic              comp_we, comp_wdata, comp_re, comp_rdata;
    logic [AW-1:0]     comp_waddr, comp_raddr;
    logic              pl_we, pl_re;
    logic [PAW-1:0]    pl_waddr, pl_raddr;
    logic [NW-1:0]     pl_wdata, pl_rdata;
    logic              mod_start;
    lps_pkg::t_mod_stat mod_stat;

    logic              w_in_xfer;
    logic [31:0]       w_lim32;
    logic [31:0]       w_in_q32, w_in_idx32, w_r_q32, w_r_idx32, w_nth32, w_pf32;
    logic [CW-1:0]     w_pf_inc;
    logic              w_q_ok, w_idx_ok;

    assign o_in_ready  = (r_state == lps_pkg::S_IDLE);
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Effective limit, clamped to the map size
    assign w_lim32 = (32'(r_limit) > 32'(SIEVE_SIZE)) ? 32'(SIEVE_SIZE) : 32'(r_limit);

    // Query address and range terms; zero and one are never prime
    assign w_in_q32   = 32'(i_in.query_value);
    assign w_in_idx32 = 32'(i_in.prime_index);
    assign w_r_q32    = 32'(r_q);
    assign w_r_idx32  = 32'(r_idx);
    assign w_nth32    = 32'(pl_rdata);
    assign w_pf32     = 32'(r_pf);
    assign w_pf_inc   = r_pf + CW'(1);
    assign w_q_ok     = (w_r_q32 >= 32'd2) && (w_r_q32 < 32'(r_lim));
    assign w_idx_ok   = (w_r_idx32 < w_pf32) && (w_r_idx32 < 32'(PRIME_DEPTH));

    // Next state, memory accesses and result
    always_comb begin
        n_state     = r_state;
        n_lim       = r_lim;
        n_built     = r_built;
        n_pf        = r_pf;
        n_i         = r_i;
        n_j         = r_j;
        n_p         = r_p;
        n_prod      = r_prod;
        n_clr       = r_clr;
        n_q         = r_q;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        comp_we     = 1'b0;
        comp_waddr  = r_prod[AW-1:0];
        comp_wdata  = 1'b1;
        comp_re     = 1'b0;
        comp_raddr  = w_r_q32[AW-1:0];
        pl_we       = 1'b0;
        pl_waddr    = r_pf[PAW-1:0];
        pl_wdata    = r_i[NW-1:0];
        pl_re       = 1'b0;
        pl_raddr    = w_r_idx32[PAW-1:0];
        mod_start   = 1'b0;

        case (r_state)
            lps_pkg::S_CLEAR: begin
                // Sweep the composite map to zero
                comp_we    = 1'b1;
                comp_waddr = r_clr;
                comp_wdata = 1'b0;
                n_clr      = r_clr + AW'(1);
                if (r_clr == AW'(SIEVE_SIZE - 1)) begin
                    n_state = lps_pkg::S_IDLE;
                end
            end
            lps_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    n_q   = i_in.query_value;
                    n_idx = i_in.prime_index;
                    if (r_built) begin
                        // Issue both query reads in the transfer cycle
                        comp_re    = 1'b1;
                        comp_raddr = w_in_q32[AW-1:0];
                        pl_re      = 1'b1;
                        pl_raddr   = w_in_idx32[PAW-1:0];
                        n_state    = lps_pkg::S_Q_OUT;
                    end else begin
                        n_state = lps_pkg::S_B_INIT;
                    end
                end
            end
            lps_pkg::S_B_INIT: begin
                // Latch the limit and start at two
                n_lim = w_lim32[LW-1:0];
                n_pf  = '0;
                n_i   = LW'(2);
                if (w_lim32 <= 32'd2) begin
                    n_built = 1'b1;
                    n_state = lps_pkg::S_Q_READ;
                end else begin
                    n_state = lps_pkg::S_B_RDI;
                end
            end
            lps_pkg::S_B_RDI: begin
                comp_re    = 1'b1;
                comp_raddr = r_i[AW-1:0];
                n_state    = lps_pkg::S_B_CHK;
            end
            lps_pkg::S_B_CHK: begin
                // Append an unmarked integer while the list has room
                n_j = '0;
                if (!comp_rdata && (w_pf32 < 32'(PRIME_DEPTH))) begin
                    pl_we   = 1'b1;
                    n_pf    = w_pf_inc;
                    n_state = lps_pkg::S_B_RDP;
                end else if (r_pf == '0) begin
                    n_state = lps_pkg::S_B_NEXT;
                end else begin
                    n_state = lps_pkg::S_B_RDP;
                end
            end
            lps_pkg::S_B_RDP: begin
                pl_re    = 1'b1;
                pl_raddr = r_j[PAW-1:0];
                n_state  = lps_pkg::S_B_MUL;
            end
            lps_pkg::S_B_MUL: begin
                n_p     = pl_rdata;
                n_prod  = PW'(r_i) * PW'(pl_rdata);
                n_state = lps_pkg::S_B_MARK;
            end
            lps_pkg::S_B_MARK: begin
                // Mark the product if it is below the limit, then test divisibility
                if (r_prod >= PW'(r_lim)) begin
                    n_state = lps_pkg::S_B_NEXT;
                end else begin
                    comp_we   = 1'b1;
                    mod_start = 1'b1;
                    n_state   = lps_pkg::S_B_DIV;
                end
            end
            lps_pkg::S_B_DIV: begin
                if (mod_stat.done) begin
                    if (mod_stat.rem_zero || ((r_j + CW'(1)) == r_pf)) begin
                        n_state = lps_pkg::S_B_NEXT;
                    end else begin
                        n_j     = r_j + CW'(1);
                        n_state = lps_pkg::S_B_RDP;
                    end
                end
            end
            lps_pkg::S_B_NEXT: begin
                if (({1'b0, r_i} + (LW+1)'(1)) == {1'b0, r_lim}) begin
                    n_built = 1'b1;
                    n_state = lps_pkg::S_Q_READ;
                end else begin
                    n_i     = r_i + LW'(1);
                    n_state = lps_pkg::S_B_RDI;
                end
            end
            lps_pkg::S_Q_READ: begin
                comp_re = 1'b1;
                pl_re   = 1'b1;
                n_state = lps_pkg::S_Q_OUT;
            end
            lps_pkg::S_Q_OUT: begin
                // Load the result once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out.value_is_prime = w_q_ok && !comp_rdata;
                    n_out.nth_prime      = w_idx_ok ? w_nth32[lps_pkg::VALUE_W-1:0] : '0;
                    n_out.prime_total    = w_pf32[lps_pkg::TOTAL_W-1:0];
                    n_out.index_in_range = w_idx_ok;
                    n_out_valid          = 1'b1;
                    n_state              = lps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lps_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lps_pkg::S_CLEAR;
            r_limit     <= lps_pkg::LIMIT_RESET;
            r_lim       <= '0;
            r_built     <= 1'b0;
            r_pf        <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lim       <= n_lim;
            r_built     <= n_built;
            r_pf        <= n_pf;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_p    <= n_p;
        r_prod <= n_prod;
        r_q    <= n_q;
        r_idx  <= n_idx;
        r_out  <= n_out;
    end

    // Composite map
    lps_ram #(
        .WIDTH (1),
        .DEPTH (SIEVE_SIZE)
    ) u_comp (
        .i_clk   (i_clk),
        .i_we    (comp_we),
        .i_waddr (comp_waddr),
        .i_wdata (comp_wdata),
        .i_re    (comp_re),
        .i_raddr (comp_raddr),
        .o_rdata (comp_rdata)
    );

    // Prime list
    lps_ram #(
        .WIDTH (NW),
        .DEPTH (PRIME_DEPTH)
    ) u_plist (
        .i_clk   (i_clk),
        .i_we    (pl_we),
        .i_waddr (pl_waddr),
        .i_wdata (pl_wdata),
        .i_re    (pl_re),
        .i_raddr (pl_raddr),
        .o_rdata (pl_rdata)
    );

    // Divisibility test of the current integer by the current prime
    lps_mod #(
        .W (NW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_i[NW-1:0]),
        .i_divisor  (r_p),
        .o_stat     (mod_stat)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: rtl/lps_checker.sv
// Port-level assertions for the linear prime sieve, bound to the top level.
module lps_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input lps_pkg::t_lps_out i_out
);

    // A query transfer closes the query channel in the cycle after it
    a_in_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("query channel ready right after a transfer");

    // A new result is raised only from a state in which the query channel is closed
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result raised while query channel was open");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out)))
        else $error("stalled result dropped or changed");

endmodule

bind linear_prime_sieve lps_checker u_lps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out       (o_out)
);
